// ===== design/csw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_pkg
// Shared types and constants for the clock / stopwatch block.
// ----------------------------------------------------------------------------
package csw_pkg;

	localparam int DIGITS   = 6;
	localparam int DIGIT_W  = 4;
	localparam int THRESH_W = 8;
	localparam int CURSOR_W = 3;
	localparam int MODE_W   = 2;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd5;
	localparam logic [CURSOR_W-1:0] CURSOR_LAST  = 3'd5;

	// digit 0 is the leftmost (hour tens / minute tens)
	localparam logic [DIGITS-1:0][DIGIT_W-1:0] CLK_LIMIT =
		{4'd10, 4'd6, 4'd10, 4'd6, 4'd10, 4'd3};
	localparam logic [DIGITS-1:0][DIGIT_W-1:0] SW_LIMIT =
		{4'd10, 4'd10, 4'd10, 4'd6, 4'd10, 4'd2};

	localparam logic [DIGIT_W-1:0] HOUR_TENS_HI        = 4'd2;
	localparam logic [DIGIT_W-1:0] HOUR_UNITS_HI_LIMIT = 4'd4;
	localparam logic [DIGIT_W-1:0] HOUR_UNITS_LAST     = 4'd3;

	typedef enum logic [MODE_W-1:0] {
		MODE_CLOCK     = 2'd0,
		MODE_STOPWATCH = 2'd1,
		MODE_SET       = 2'd2
	} mode_t;

	typedef struct packed {
		logic held;
		logic long_press;
		logic short_press;
	} btn_status_t;

	typedef struct packed {
		logic [MODE_W-1:0]                mode;
		logic [DIGITS-1:0][DIGIT_W-1:0]   digit;
		logic [CURSOR_W-1:0]              cursor;
		logic                             running;
	} res_t;

endpackage
`default_nettype wire

// ===== design/csw_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_tick_if / csw_status_if
// Valid/ready channels for the incoming ticks and the displayed status.
// ----------------------------------------------------------------------------
interface csw_tick_if;
	logic valid;
	logic ready;
	logic button_one_pressed;
	logic button_two_pressed;

	modport source (output valid, button_one_pressed, button_two_pressed, input ready);
	modport sink   (input valid, button_one_pressed, button_two_pressed, output ready);
endinterface

interface csw_status_if;
	logic       valid;
	logic       ready;
	logic [1:0] current_mode;
	logic [3:0] left_tens;
	logic [3:0] left_units;
	logic [3:0] middle_tens;
	logic [3:0] middle_units;
	logic [3:0] right_tens;
	logic [3:0] right_units;
	logic [2:0] cursor_position;
	logic       stopwatch_running;

	modport source (output valid, current_mode, left_tens, left_units, middle_tens,
		middle_units, right_tens, right_units, cursor_position, stopwatch_running,
		input ready);
	modport sink   (input valid, current_mode, left_tens, left_units, middle_tens,
		middle_units, right_tens, right_units, cursor_position, stopwatch_running,
		output ready);
endinterface
`default_nettype wire

// ===== design/clock_stopwatch_with_buttons.sv =====
// One request on tick is one 10 ms tick carrying both button levels; each
// tick yields exactly one status request showing the mode, the six digits
// shown (stopwatch in stopwatch mode, time of day otherwise), the cursor and
// the run flag after that tick. The digits are two chains of BCD cells
// whose carries ripple combinationally, so the block takes one tick per
// clock while tick.ready is high. A two-entry output buffer lets a new
// tick in while the previous status waits; tick.ready drops only when both
// entries are full. The long-press threshold register may be written at any
// time the block is idle and resets to 5.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clock_stopwatch_with_buttons
// Time-of-day clock and stopwatch controlled by two buttons.
// ----------------------------------------------------------------------------
module clock_stopwatch_with_buttons #(
	parameter int TICKS_PER_SAMPLE  = 10,
	parameter int TICKS_PER_SECOND  = 100,
	parameter int PRESS_COUNT_WIDTH = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_wr_en,
	input  wire logic [csw_pkg::THRESH_W-1:0] cfg_wr_data,
	csw_tick_if.sink                          tick,
	csw_status_if.source                      status
);
	import csw_pkg::*;

	localparam int SMP_W = $clog2(TICKS_PER_SAMPLE + 1);
	localparam int SEC_W = $clog2(TICKS_PER_SECOND + 1);

	logic [THRESH_W-1:0] thresh_q;
	logic [SMP_W-1:0]    smp_q;
	logic [SEC_W-1:0]    sec_q;
	mode_t               mode_q, mode_d;
	logic [CURSOR_W-1:0] cursor_q, cursor_d;
	logic                run_q, run_d;

	logic accept, sample, sec_tick, set_en, sw_clr;
	btn_status_t btn [2];

	logic [DIGITS-1:0][DIGIT_W-1:0] clk_val, clk_nxt, clk_lim, sw_val, sw_nxt;
	logic [DIGITS-1:0]              clk_wrap, clk_tk, clk_inc, clk_clr, set_sel;
	logic [DIGITS-1:0]              sw_wrap, sw_tk;
	logic                           hour_hi;

	res_t res_d, out_q, skid_q;
	logic out_v_q, skid_v_q, out_take;

	// ---- handshake ----
	assign tick.ready = !skid_v_q;
	assign accept     = tick.valid && tick.ready;
	assign out_take   = out_v_q && status.ready;

	assign sample   = (smp_q == '0);
	assign sec_tick = (sec_q == '0) && (mode_q != MODE_SET);

	// ---- buttons ----
	csw_button_cell #(.LEN_W(PRESS_COUNT_WIDTH)) u_btn0 (
		.clk, .arst_n, .en(accept && sample), .pressed(tick.button_one_pressed),
		.threshold(thresh_q), .status(btn[0])
	);
	csw_button_cell #(.LEN_W(PRESS_COUNT_WIDTH)) u_btn1 (
		.clk, .arst_n, .en(accept && sample), .pressed(tick.button_two_pressed),
		.threshold(thresh_q), .status(btn[1])
	);

	// ---- mode logic ----
	always_comb begin
		mode_d   = mode_q;
		run_d    = run_q;
		cursor_d = cursor_q;
		set_en   = 1'b0;
		sw_clr   = 1'b0;
		if (sample) begin
			case (mode_q)
				MODE_CLOCK: begin
					if (btn[0].short_press) begin
						mode_d = MODE_STOPWATCH;
					end else if (btn[0].long_press) begin
						mode_d = MODE_SET;
					end
				end
				MODE_STOPWATCH: begin
					if (btn[0].short_press) begin
						mode_d = MODE_CLOCK;
					end
					if (btn[1].short_press) begin
						run_d = !run_q;
					end else if (btn[1].long_press) begin
						sw_clr = 1'b1;
					end
				end
				MODE_SET: begin
					set_en = btn[0].held;
					if (btn[1].held) begin
						cursor_d = (cursor_q >= CURSOR_LAST) ? '0 : cursor_q + CURSOR_W'(1);
					end
					if (btn[0].long_press) begin
						mode_d = MODE_CLOCK;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---- time-of-day and stopwatch chains ----
	assign hour_hi = clk_val[0] >= HOUR_TENS_HI;

	always_comb begin
		clk_tk[DIGITS-1] = sec_tick;
		sw_tk[DIGITS-1]  = run_q;
		for (int i = DIGITS - 2; i >= 0; i--) begin
			clk_tk[i] = clk_tk[i+1] && clk_wrap[i+1];
			sw_tk[i]  = sw_tk[i+1] && sw_wrap[i+1];
		end
		clk_lim    = CLK_LIMIT;
		clk_lim[1] = hour_hi ? HOUR_UNITS_HI_LIMIT : CLK_LIMIT[1];
		for (int i = 0; i < DIGITS; i++) begin
			set_sel[i] = set_en && (cursor_q == CURSOR_W'(i));
			clk_inc[i] = clk_tk[i] || set_sel[i];
			clk_clr[i] = 1'b0;
		end
		// hours roll over from 23 straight to 00
		clk_inc[0] = (clk_tk[0] && !hour_hi) || set_sel[0];
		clk_clr[0] = clk_tk[0] && hour_hi;
		// raising hour tens to 2 drops an out-of-range hour units
		clk_clr[1] = set_sel[0] && (clk_nxt[0] == HOUR_TENS_HI)
			&& (clk_val[1] > HOUR_UNITS_LAST);
	end

	for (genvar g = 0; g < DIGITS; g++) begin : g_cells
		csw_digit_cell u_clk (
			.clk, .arst_n, .en(accept), .inc(clk_inc[g]), .clr(clk_clr[g]),
			.limit(clk_lim[g]), .value(clk_val[g]), .nxt(clk_nxt[g]), .wrap(clk_wrap[g])
		);
		csw_digit_cell u_sw (
			.clk, .arst_n, .en(accept), .inc(sw_tk[g]), .clr(sw_clr),
			.limit(SW_LIMIT[g]), .value(sw_val[g]), .nxt(sw_nxt[g]), .wrap(sw_wrap[g])
		);
	end

	// ---- result ----
	always_comb begin
		res_d.mode    = mode_d;
		res_d.digit   = (mode_d == MODE_STOPWATCH) ? sw_nxt : clk_nxt;
		res_d.cursor  = cursor_d;
		res_d.running = run_d;
	end

	// ---- state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_wr_en) begin
			thresh_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q    <= '0;
			sec_q    <= '0;
			mode_q   <= MODE_CLOCK;
			cursor_q <= '0;
			run_q    <= 1'b0;
		end else if (accept) begin
			smp_q    <= (smp_q == SMP_W'(TICKS_PER_SAMPLE - 1)) ? '0 : smp_q + SMP_W'(1);
			sec_q    <= (sec_q == SEC_W'(TICKS_PER_SECOND - 1)) ? '0 : sec_q + SEC_W'(1);
			mode_q   <= mode_d;
			cursor_q <= cursor_d;
			run_q    <= run_d;
		end
	end

	// ---- two-entry output buffer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (accept) begin
			if (!out_v_q || out_take) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (out_take) begin
			out_v_q  <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (!out_v_q || out_take) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end else if (out_take && skid_v_q) begin
			out_q <= skid_q;
		end
	end

	assign status.valid             = out_v_q;
	assign status.current_mode      = out_q.mode;
	assign status.left_tens         = out_q.digit[0];
	assign status.left_units        = out_q.digit[1];
	assign status.middle_tens       = out_q.digit[2];
	assign status.middle_units      = out_q.digit[3];
	assign status.right_tens        = out_q.digit[4];
	assign status.right_units       = out_q.digit[5];
	assign status.cursor_position   = out_q.cursor;
	assign status.stopwatch_running = out_q.running;

endmodule
`default_nettype wire

// ===== design/csw_digit_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_digit_cell
// One BCD digit of a counter chain: increments, wraps at its limit, clears.
// ----------------------------------------------------------------------------
module csw_digit_cell (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        inc,
	input  wire logic                        clr,
	input  wire logic [csw_pkg::DIGIT_W-1:0] limit,
	output logic      [csw_pkg::DIGIT_W-1:0] value,
	output logic      [csw_pkg::DIGIT_W-1:0] nxt,
	output logic                             wrap
);
	import csw_pkg::*;

	logic [DIGIT_W-1:0] value_q;
	logic [DIGIT_W:0]   sum;

	assign sum   = {1'b0, value_q} + (DIGIT_W+1)'(1);
	assign wrap  = sum >= {1'b0, limit};
	assign value = value_q;

	always_comb begin
		if (clr) begin
			nxt = '0;
		end else if (inc) begin
			nxt = wrap ? '0 : sum[DIGIT_W-1:0];
		end else begin
			nxt = value_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
		end else if (en) begin
			value_q <= nxt;
		end
	end
endmodule
`default_nettype wire

// ===== design/csw_button_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_button_cell
// Press-length tracking for one button; classifies short and long presses.
// ----------------------------------------------------------------------------
module csw_button_cell #(
	parameter int LEN_W = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         pressed,
	input  wire logic [csw_pkg::THRESH_W-1:0] threshold,
	output csw_pkg::btn_status_t              status
);
	import csw_pkg::*;

	localparam int CMP_W = (LEN_W > THRESH_W) ? LEN_W : THRESH_W;

	logic             held_q, held_d;
	logic             long_q, long_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [CMP_W-1:0] len_x, thr_x;

	assign thr_x = CMP_W'(threshold);
	assign len_x = CMP_W'(len_d);

	always_comb begin
		if (pressed) begin
			held_d = 1'b1;
			len_d  = (&len_q) ? len_q : len_q + LEN_W'(1);
			long_d = long_q || (len_x > thr_x);
		end else begin
			held_d = 1'b0;
			len_d  = held_q ? len_q : '0;
			long_d = 1'b0;
		end
	end

	assign status.held        = held_d;
	assign status.long_press  = long_d;
	assign status.short_press = !held_d && (len_d != '0) && (len_x <= thr_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 1'b0;
			long_q <= 1'b0;
			len_q  <= '0;
		end else if (en) begin
			held_q <= held_d;
			long_q <= long_d;
			len_q  <= len_d;
		end
	end
endmodule
`default_nettype wire

// ===== design/csw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csw_checker
// Port-level checks on the clock / stopwatch block, bound to the top level.
// ----------------------------------------------------------------------------
module csw_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       tick_valid,
	input wire logic       tick_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] mode,
	input wire logic [3:0] d0,
	input wire logic [3:0] d1,
	input wire logic [3:0] d2,
	input wire logic [3:0] d3,
	input wire logic [3:0] d4,
	input wire logic [3:0] d5,
	input wire logic [2:0] cursor
);
	import csw_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("status request dropped while stalled");

	a_request_out: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> out_valid)
		else $error("accepted tick produced no status");

	a_bcd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> d0 <= 4'd9 && d1 <= 4'd9 && d2 <= 4'd5 && d3 <= 4'd9
			&& d4 <= 4'd9 && d5 <= 4'd9)
		else $error("digit out of range");

	a_hours: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && mode != MODE_STOPWATCH |->
			d0 < 4'd2 || (d0 == 4'd2 && d1 <= 4'd3))
		else $error("hour out of range");

	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor <= CURSOR_LAST && (mode != MODE_STOPWATCH || d0 <= 4'd1))
		else $error("cursor or stopwatch minutes out of range");

endmodule

bind clock_stopwatch_with_buttons csw_checker u_csw_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_valid (tick.valid),
	.tick_ready (tick.ready),
	.out_valid  (status.valid),
	.out_ready  (status.ready),
	.mode       (status.current_mode),
	.d0         (status.left_tens),
	.d1         (status.left_units),
	.d2         (status.middle_tens),
	.d3         (status.middle_units),
	.d4         (status.right_tens),
	.d5         (status.right_units),
	.cursor     (status.cursor_position)
);
`default_nettype wire
